// File: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int PIX_W     = 8;
    localparam int HUE_W     = 12;
    localparam int QUO_W     = 10;
    localparam int DIV_NUM_W = 18;

    localparam int HUE_SIXTH  = 600;
    localparam int HUE_FULL   = 3600;
    localparam int SAT_SCALE  = 255;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        sector_t            sector;
        logic               diff_neg;
        logic               black;
        logic               grey;
        logic [PIX_W-1:0]   mx;
        logic               last;
    } hsv_side_t;

endpackage

// File: rtl/core/rgbhsv_div.sv
module rgbhsv_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [rgbhsv_pkg::DIV_NUM_W-1:0]   hue_num,
    input  logic [rgbhsv_pkg::PIX_W-1:0]       hue_den,
    input  logic [rgbhsv_pkg::DIV_NUM_W-1:0]   sat_num,
    input  logic [rgbhsv_pkg::PIX_W-1:0]       sat_den,
    input  rgbhsv_pkg::hsv_side_t              side_in,
    output logic                               out_valid,
    output logic [rgbhsv_pkg::QUO_W-1:0]       hue_quo,
    output logic                               hue_rem_nz,
    output logic [rgbhsv_pkg::QUO_W-1:0]       sat_quo,
    output rgbhsv_pkg::hsv_side_t              side_out
);
    import rgbhsv_pkg::*;

    // one quotient bit per stage, MSB first; both divides share the stage timing
    logic                   valid_reg   [QUO_W];
    logic [DIV_NUM_W-1:0]   hue_rem_reg [QUO_W];
    logic [PIX_W-1:0]       hue_den_reg [QUO_W];
    logic [QUO_W-1:0]       hue_quo_reg [QUO_W];
    logic [DIV_NUM_W-1:0]   sat_rem_reg [QUO_W];
    logic [PIX_W-1:0]       sat_den_reg [QUO_W];
    logic [QUO_W-1:0]       sat_quo_reg [QUO_W];
    hsv_side_t              side_reg    [QUO_W];

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++) begin : g_stage
            localparam int SH = QUO_W - 1 - g;

            logic                   valid_prev;
            logic [DIV_NUM_W-1:0]   hue_rem_prev;
            logic [PIX_W-1:0]       hue_den_prev;
            logic [QUO_W-1:0]       hue_quo_prev;
            logic [DIV_NUM_W-1:0]   sat_rem_prev;
            logic [PIX_W-1:0]       sat_den_prev;
            logic [QUO_W-1:0]       sat_quo_prev;
            hsv_side_t              side_prev;

            logic [DIV_NUM_W-1:0]   hue_sh;
            logic [DIV_NUM_W-1:0]   sat_sh;
            logic                   hue_take;
            logic                   sat_take;
            logic [DIV_NUM_W-1:0]   hue_rem_next;
            logic [DIV_NUM_W-1:0]   sat_rem_next;
            logic [QUO_W-1:0]       hue_quo_next;
            logic [QUO_W-1:0]       sat_quo_next;

            if (g == 0) begin : g_first
                always_comb
                begin
                    valid_prev   = in_valid;
                    hue_rem_prev = hue_num;
                    hue_den_prev = hue_den;
                    hue_quo_prev = '0;
                    sat_rem_prev = sat_num;
                    sat_den_prev = sat_den;
                    sat_quo_prev = '0;
                    side_prev    = side_in;
                end
            end else begin : g_next
                always_comb
                begin
                    valid_prev   = valid_reg[g-1];
                    hue_rem_prev = hue_rem_reg[g-1];
                    hue_den_prev = hue_den_reg[g-1];
                    hue_quo_prev = hue_quo_reg[g-1];
                    sat_rem_prev = sat_rem_reg[g-1];
                    sat_den_prev = sat_den_reg[g-1];
                    sat_quo_prev = sat_quo_reg[g-1];
                    side_prev    = side_reg[g-1];
                end
            end

            always_comb
            begin
                hue_sh       = DIV_NUM_W'(hue_den_prev) << SH;
                sat_sh       = DIV_NUM_W'(sat_den_prev) << SH;
                hue_take     = hue_rem_prev >= hue_sh;
                sat_take     = sat_rem_prev >= sat_sh;
                hue_rem_next = hue_take ? hue_rem_prev - hue_sh : hue_rem_prev;
                sat_rem_next = sat_take ? sat_rem_prev - sat_sh : sat_rem_prev;
                hue_quo_next = hue_quo_prev | (QUO_W'(hue_take) << SH);
                sat_quo_next = sat_quo_prev | (QUO_W'(sat_take) << SH);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                hue_rem_reg[g] <= hue_rem_next;
                hue_den_reg[g] <= hue_den_prev;
                hue_quo_reg[g] <= hue_quo_next;
                sat_rem_reg[g] <= sat_rem_next;
                sat_den_reg[g] <= sat_den_prev;
                sat_quo_reg[g] <= sat_quo_next;
                side_reg[g]    <= side_prev;
            end
        end
    endgenerate

    assign out_valid  = valid_reg[QUO_W-1];
    assign hue_quo    = hue_quo_reg[QUO_W-1];
    assign hue_rem_nz = hue_rem_reg[QUO_W-1] != '0;
    assign sat_quo    = sat_quo_reg[QUO_W-1];
    assign side_out   = side_reg[QUO_W-1];

    a_hue_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hue_den_reg[QUO_W-1] != '0
        |-> hue_rem_reg[QUO_W-1] < DIV_NUM_W'(hue_den_reg[QUO_W-1]))
        else $error("hue remainder not below divisor");

    a_sat_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat_den_reg[QUO_W-1] != '0
        |-> sat_rem_reg[QUO_W-1] < DIV_NUM_W'(sat_den_reg[QUO_W-1]))
        else $error("saturation remainder not below divisor");

    a_sat_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat_den_reg[QUO_W-1] != '0
        |-> sat_quo_reg[QUO_W-1][QUO_W-1:PIX_W] == '0)
        else $error("saturation quotient overflow");

endmodule

// File: rtl/core/rgb_to_hsv_converter.sv
// channel   direction  transfer                 fields
// pixel     in         start && !busy           red, green, blue, last_pixel
// result    out        done (one cycle strobe)  hue_tenths, saturation, brightness,
//                                               hue_undefined, last_out
//
// One pixel per clock; a result passes the min/max, multiply, divide and output stages
// in that order, and the min/max stage is loaded on the edge that takes its pixel.
// The divide pipeline gives one quotient bit per stage, 10 stages.
// busy is always low; reset clears only the valid bits in the pipeline.
// The receiver cannot stall, so results leave on the strobe cycle and are gone.
module rgb_to_hsv_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rgbhsv_pkg::PIX_W-1:0]    red,
    input  logic [rgbhsv_pkg::PIX_W-1:0]    green,
    input  logic [rgbhsv_pkg::PIX_W-1:0]    blue,
    input  logic                            last_pixel,
    output logic                            done,
    output logic [rgbhsv_pkg::HUE_W-1:0]    hue_tenths,
    output logic [rgbhsv_pkg::PIX_W-1:0]    saturation,
    output logic [rgbhsv_pkg::PIX_W-1:0]    brightness,
    output logic                            hue_undefined,
    output logic                            last_out
);
    import rgbhsv_pkg::*;

    // stage 1: max/min, sector, |diff|
    logic [PIX_W-1:0]   rg_max;
    logic [PIX_W-1:0]   rg_min;
    logic [PIX_W-1:0]   mx_next;
    logic [PIX_W-1:0]   mn_next;
    logic signed [PIX_W:0] diff_s;
    logic [PIX_W:0]     diff_abs;
    hsv_side_t          s1_side_next;

    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_delta_reg;
    logic [PIX_W-1:0]   s1_absdiff_reg;
    hsv_side_t          s1_side_reg;

    always_comb
    begin
        rg_max  = (green > red) ? green : red;
        rg_min  = (green < red) ? green : red;
        mx_next = (blue > rg_max) ? blue : rg_max;
        mn_next = (blue < rg_min) ? blue : rg_min;

        if (red == mx_next)
        begin
            s1_side_next.sector = SECT_RED;
            diff_s = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == mx_next)
        begin
            s1_side_next.sector = SECT_GREEN;
            diff_s = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            s1_side_next.sector = SECT_BLUE;
            diff_s = $signed({1'b0, red}) - $signed({1'b0, green});
        end

        diff_abs               = diff_s[PIX_W] ? 9'(-diff_s) : 9'(diff_s);
        s1_side_next.diff_neg  = diff_s[PIX_W];
        s1_side_next.black     = mx_next == '0;
        s1_side_next.grey      = mx_next == mn_next;
        s1_side_next.mx        = mx_next;
        s1_side_next.last      = last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_delta_reg   <= mx_next - mn_next;
        s1_absdiff_reg <= diff_abs[PIX_W-1:0];
        s1_side_reg    <= s1_side_next;
    end

    // stage 2: scale numerators
    logic                   s2_valid_reg;
    logic [DIV_NUM_W-1:0]   s2_hue_num_reg;
    logic [DIV_NUM_W-1:0]   s2_sat_num_reg;
    logic [PIX_W-1:0]       s2_delta_reg;
    hsv_side_t              s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_hue_num_reg <= DIV_NUM_W'(s1_absdiff_reg) * DIV_NUM_W'(HUE_SIXTH);
        s2_sat_num_reg <= DIV_NUM_W'(s1_delta_reg) * DIV_NUM_W'(SAT_SCALE);
        s2_delta_reg   <= s1_delta_reg;
        s2_side_reg    <= s1_side_reg;
    end

    // divide pipeline
    logic               dv_valid;
    logic [QUO_W-1:0]   dv_hue_quo;
    logic               dv_hue_rem_nz;
    logic [QUO_W-1:0]   dv_sat_quo;
    hsv_side_t          dv_side;

    rgbhsv_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid_reg),
        .hue_num    (s2_hue_num_reg),
        .hue_den    (s2_delta_reg),
        .sat_num    (s2_sat_num_reg),
        .sat_den    (s2_side_reg.mx),
        .side_in    (s2_side_reg),
        .out_valid  (dv_valid),
        .hue_quo    (dv_hue_quo),
        .hue_rem_nz (dv_hue_rem_nz),
        .sat_quo    (dv_sat_quo),
        .side_out   (dv_side)
    );

    // output stage: sector offset and wrap
    logic [HUE_W-1:0]   q_ext;
    logic [HUE_W-1:0]   sect_off;
    logic [HUE_W-1:0]   hue_next;
    logic [PIX_W-1:0]   sat_next;
    logic               flat;

    logic               done_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [PIX_W-1:0]   sat_reg;
    logic [PIX_W-1:0]   bright_reg;
    logic               undef_reg;
    logic               last_reg;

    always_comb
    begin
        q_ext = HUE_W'(dv_hue_quo);
        flat  = dv_side.black || dv_side.grey;

        case (dv_side.sector)
            SECT_RED:   sect_off = '0;
            SECT_GREEN: sect_off = HUE_W'(2 * HUE_SIXTH);
            SECT_BLUE:  sect_off = HUE_W'(4 * HUE_SIXTH);
            default:    sect_off = '0;
        endcase

        if (dv_side.sector == SECT_RED)
        begin
            // truncation toward zero, then wrap negatives
            if (dv_side.diff_neg && q_ext != '0)
            begin
                hue_next = HUE_W'(HUE_FULL) - q_ext;
            end
            else
            begin
                hue_next = q_ext;
            end
        end
        else if (dv_side.diff_neg)
        begin
            // numerator stays positive here, so the quotient floors
            hue_next = sect_off - q_ext - HUE_W'(dv_hue_rem_nz);
        end
        else
        begin
            hue_next = sect_off + q_ext;
        end

        sat_next = dv_sat_quo[PIX_W-1:0];

        if (flat)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sat_reg    <= sat_next;
        bright_reg <= dv_side.mx;
        undef_reg  <= dv_side.black;
        last_reg   <= dv_side.last;
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign hue_tenths    = hue_reg;
    assign saturation    = sat_reg;
    assign brightness    = bright_reg;
    assign hue_undefined = undef_reg;
    assign last_out      = last_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue_tenths < HUE_W'(HUE_FULL))
        else $error("hue out of range");

    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && hue_undefined |-> brightness == '0 && saturation == '0 && hue_tenths == '0)
        else $error("black pixel with nonzero result");

    a_flat_hue: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturation == '0 |-> hue_tenths == '0)
        else $error("unsaturated pixel with nonzero hue");

endmodule
